>>> sv/fqkd_pkg.sv
`timescale 1ns / 1ps

package fqkd_pkg;

	// Default queue depth
	localparam int DEPTH_DEF = 16;

	// Field widths
	localparam int PID_W = 22;
	localparam int PRI_W = 8;
	localparam int RUN_W = 16;

	// Request codes
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_DEL  = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	// One stored process record
	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [PRI_W-1:0] pri;
		logic [RUN_W-1:0] run;
	} rec_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_SHIFT
	} state_t;

endpackage

>>> sv/fifo_queue_with_keyed_delete.sv
`timescale 1ns / 1ps

// Bounded FIFO of process records (pid, priority, run time) held in one
// single-port-read, single-port-write RAM used as a ring. A request is taken
// when start is high and busy is low; its result appears on the result ports
// for exactly one cycle with done high and cannot be held off, so the
// receiver must capture it in that cycle. A push, a no-op, a pop on an empty
// queue and a delete on an empty queue return in the cycle after the transfer.
// A pop on a non-empty queue takes the head record from its RAM read in S_POP
// before it returns. A delete scans from the head one entry per cycle and, if
// it finds the key, then moves every later entry down one slot, one per cycle,
// through the single RAM read port. For a pop or a delete on a non-empty queue,
// busy is high from the cycle after the transfer until the result cycle.
module fifo_queue_with_keyed_delete #(
	parameter int DEPTH = fqkd_pkg::DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 mode,
	input  logic [fqkd_pkg::PID_W-1:0] pid,
	input  logic [fqkd_pkg::PRI_W-1:0] priority_req,
	input  logic [fqkd_pkg::RUN_W-1:0] run_time,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [fqkd_pkg::PID_W-1:0] out_pid,
	output logic [fqkd_pkg::PRI_W-1:0] out_priority,
	output logic [fqkd_pkg::RUN_W-1:0] out_run_time,
	output logic [CNT_W-1:0]           occupancy
);

	localparam int SUM_W = CNT_W + 1;

	// Control state
	fqkd_pkg::state_t state_q, state_d;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] work_ptr_q;
	logic [PTR_W-1:0] idx_q;
	logic             done_q;

	// Request and result payload
	logic [fqkd_pkg::PID_W-1:0] key_q;
	logic [1:0]                 status_q;
	fqkd_pkg::rec_t             res_q;
	logic [CNT_W-1:0]           occ_q;

	// Record RAM
	fqkd_pkg::rec_t mem_q [DEPTH];
	fqkd_pkg::rec_t rd_q;
	logic [PTR_W-1:0] rd_addr;
	logic             mem_we;
	logic [PTR_W-1:0] wr_addr;
	fqkd_pkg::rec_t   wr_data;

	// Ring pointer arithmetic
	logic [PTR_W-1:0] head_inc, work_inc, work_inc2, tail_ptr;
	logic [SUM_W-1:0] tail_sum;
	logic             accept, full, empty, hit, last_scan, last_shift;

	always_comb begin
		head_inc  = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
		work_inc  = (work_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : work_ptr_q + PTR_W'(1);
		work_inc2 = (work_inc == PTR_W'(DEPTH - 1)) ? '0 : work_inc + PTR_W'(1);
		tail_sum  = SUM_W'(head_q) + SUM_W'(cnt_q);
		if (tail_sum >= SUM_W'(DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(DEPTH);
		end
		tail_ptr  = tail_sum[PTR_W-1:0];
	end

	// Status flags
	assign accept     = start && (state_q == fqkd_pkg::S_IDLE);
	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign empty      = (cnt_q == '0);
	assign hit        = (rd_q.pid == key_q);
	assign last_scan  = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
	assign last_shift = (CNT_W'(idx_q) == cnt_q - CNT_W'(2));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fqkd_pkg::S_IDLE: begin
				if (accept && mode == fqkd_pkg::MODE_POP && !empty) begin
					state_d = fqkd_pkg::S_POP;
				end else if (accept && mode == fqkd_pkg::MODE_DEL && !empty) begin
					state_d = fqkd_pkg::S_SCAN;
				end
			end
			fqkd_pkg::S_POP: begin
				state_d = fqkd_pkg::S_IDLE;
			end
			fqkd_pkg::S_SCAN: begin
				if (hit && !last_scan) begin
					state_d = fqkd_pkg::S_SHIFT;
				end else if (hit || last_scan) begin
					state_d = fqkd_pkg::S_IDLE;
				end
			end
			fqkd_pkg::S_SHIFT: begin
				if (last_shift) begin
					state_d = fqkd_pkg::S_IDLE;
				end
			end
			default: state_d = fqkd_pkg::S_IDLE;
		endcase
	end

	// RAM controls and handshake outputs
	always_comb begin
		busy    = (state_q != fqkd_pkg::S_IDLE);
		rd_addr = head_q;
		mem_we  = 1'b0;
		wr_addr = tail_ptr;
		wr_data = '{pid: pid, pri: priority_req, run: run_time};
		case (state_q)
			fqkd_pkg::S_IDLE: begin
				rd_addr = head_q;
				mem_we  = accept && mode == fqkd_pkg::MODE_PUSH && !full;
				wr_addr = tail_ptr;
			end
			fqkd_pkg::S_POP: begin
				rd_addr = head_q;
			end
			fqkd_pkg::S_SCAN: begin
				rd_addr = work_inc;
			end
			fqkd_pkg::S_SHIFT: begin
				// move the entry after the gap down one slot
				rd_addr = work_inc2;
				mem_we  = 1'b1;
				wr_addr = work_ptr_q;
				wr_data = rd_q;
			end
			default: begin
				rd_addr = head_q;
			end
		endcase
	end

	// RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fqkd_pkg::S_IDLE;
			head_q     <= '0;
			cnt_q      <= '0;
			work_ptr_q <= '0;
			idx_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				fqkd_pkg::S_IDLE: begin
					work_ptr_q <= head_q;
					idx_q      <= '0;
					if (accept) begin
						if (mode == fqkd_pkg::MODE_PUSH && !full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (!((mode == fqkd_pkg::MODE_POP || mode == fqkd_pkg::MODE_DEL)
								&& !empty)) begin
							done_q <= 1'b1;
						end
					end
				end
				fqkd_pkg::S_POP: begin
					head_q <= head_inc;
					cnt_q  <= cnt_q - CNT_W'(1);
					done_q <= 1'b1;
				end
				fqkd_pkg::S_SCAN: begin
					if (hit) begin
						if (last_scan) begin
							cnt_q  <= cnt_q - CNT_W'(1);
							done_q <= 1'b1;
						end
					end else if (last_scan) begin
						done_q <= 1'b1;
					end else begin
						work_ptr_q <= work_inc;
						idx_q      <= idx_q + PTR_W'(1);
					end
				end
				fqkd_pkg::S_SHIFT: begin
					work_ptr_q <= work_inc;
					idx_q      <= idx_q + PTR_W'(1);
					if (last_shift) begin
						cnt_q  <= cnt_q - CNT_W'(1);
						done_q <= 1'b1;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Key and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			fqkd_pkg::S_IDLE: begin
				key_q <= pid;
				if (accept) begin
					res_q    <= '0;
					status_q <= fqkd_pkg::STAT_OK;
					occ_q    <= cnt_q;
					case (mode)
						fqkd_pkg::MODE_PUSH: begin
							if (full) begin
								status_q <= fqkd_pkg::STAT_FULL;
							end else begin
								occ_q <= cnt_q + CNT_W'(1);
							end
						end
						fqkd_pkg::MODE_POP: begin
							status_q <= empty ? fqkd_pkg::STAT_EMPTY : fqkd_pkg::STAT_OK;
						end
						fqkd_pkg::MODE_DEL: begin
							status_q <= empty ? fqkd_pkg::STAT_NOT_FOUND : fqkd_pkg::STAT_OK;
						end
						default: begin
							status_q <= fqkd_pkg::STAT_OK;
						end
					endcase
				end
			end
			fqkd_pkg::S_POP: begin
				res_q <= rd_q;
				occ_q <= cnt_q - CNT_W'(1);
			end
			fqkd_pkg::S_SCAN: begin
				if (hit) begin
					res_q <= rd_q;
					occ_q <= cnt_q - CNT_W'(1);
				end else if (last_scan) begin
					status_q <= fqkd_pkg::STAT_NOT_FOUND;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	// Result ports
	assign done         = done_q;
	assign status       = status_q;
	assign out_pid      = res_q.pid;
	assign out_priority = res_q.pri;
	assign out_run_time = res_q.run;
	assign occupancy    = occ_q;

endmodule
